FILE: sv/crfr_pkg.sv
// Shared types and constants for the checksummed frame receiver.
package crfr_pkg;

  localparam logic [7:0]  START_BYTE    = 8'hFF;
  localparam logic [7:0]  END_BYTE      = 8'hED;
  localparam logic [7:0]  MIN_TOTAL     = 8'd5;
  localparam logic [7:0]  BODY_OVERHEAD = 8'd4;
  localparam logic [7:0]  FRAME_OVERHEAD = 8'd5;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_BODY = 3'd2,
    PH_CHK  = 3'd3,
    PH_END  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_LENGTH   = 2'd3
  } status_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    status_e    status;
    logic [7:0] frame_length;
  } result_t;

endpackage

FILE: sv/crfr_step.sv
// Frame parser state and the per-beat update that yields at most one result.
module crfr_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  logic              item_action_i,
  input  logic [7:0]        item_byte_i,
  input  logic [15:0]       limit_i,
  output logic              res_valid_o,
  output crfr_pkg::result_t res_o
);
  import crfr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  total_q, total_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] idle_q, idle_d;

  logic [16:0] idle_next;
  logic        timeout_hit;
  logic        body_done;
  logic        is_byte;

  assign is_byte     = item_action_i == ACT_BYTE;
  assign idle_next   = {1'b0, idle_q} + 17'd1;
  assign timeout_hit = (limit_i != 16'd0) && (idle_next > {1'b0, limit_i});
  assign body_done   = ({1'b0, pos_q} + 9'd1) >= ({1'b0, total_q} - {1'b0, BODY_OVERHEAD});

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (item_valid_i) begin
      if (is_byte) begin
        unique case (phase_q)
          PH_LEN: begin
            phase_d = (item_byte_i < MIN_TOTAL) ? PH_HUNT : PH_BODY;
          end
          PH_BODY: begin
            if (body_done) phase_d = PH_CHK;
          end
          PH_CHK:  phase_d = PH_END;
          PH_END:  phase_d = PH_HUNT;
          default: phase_d = (item_byte_i == START_BYTE) ? PH_LEN : PH_HUNT;
        endcase
      end else if (timeout_hit) begin
        phase_d = PH_HUNT;
      end
    end
  end

  // Data registers and the result of this beat.
  always_comb begin
    total_d     = total_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    idle_d      = idle_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_STATUS, payload_byte: 8'd0, status: ST_OK, frame_length: 8'd0};
    if (item_valid_i) begin
      if (is_byte) begin
        unique case (phase_q)
          PH_LEN: begin
            total_d = item_byte_i;
            sum_d   = sum_q + item_byte_i;
            pos_d   = 8'd0;
            if (item_byte_i < MIN_TOTAL) begin
              res_valid_o = 1'b1;
              res_o.status = ST_LENGTH;
            end
          end
          PH_BODY: begin
            sum_d = sum_q + item_byte_i;
            pos_d = pos_q + 8'd1;
            // The first body byte is the device address and is not forwarded.
            if (pos_q != 8'd0) begin
              res_valid_o        = 1'b1;
              res_o.kind         = KIND_PAYLOAD;
              res_o.payload_byte = item_byte_i;
            end
          end
          PH_CHK: begin
            sum_d = sum_q ^ item_byte_i;
          end
          PH_END: begin
            res_valid_o        = 1'b1;
            res_o.frame_length = total_q - FRAME_OVERHEAD;
            if (item_byte_i != END_BYTE) begin
              res_o.status = ST_LENGTH;
            end else if (sum_q == 8'd0) begin
              res_o.status = ST_OK;
            end else begin
              res_o.status = ST_CHECKSUM;
            end
          end
          default: begin
            if (item_byte_i == START_BYTE) begin
              sum_d = START_BYTE;
              pos_d = 8'd0;
            end
          end
        endcase
      end else if (limit_i != 16'd0) begin
        if (timeout_hit) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_TIMEOUT;
        end else begin
          idle_d = idle_next[15:0];
        end
      end
      if (res_valid_o && res_o.kind == KIND_STATUS) idle_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      total_q <= 8'd0;
      pos_q   <= 8'd0;
      sum_q   <= 8'd0;
      idle_q  <= 16'd0;
    end else begin
      phase_q <= phase_d;
      total_q <= total_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      idle_q  <= idle_d;
    end
  end

  a_status_returns_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && res_valid_o && res_o.kind == KIND_STATUS)
      |=> (phase_q == PH_HUNT && idle_q == 16'd0))
    else $error("status result did not return the parser to hunting");

  a_payload_only_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_PAYLOAD) |-> (phase_q == PH_BODY && pos_q != 8'd0))
    else $error("payload result outside the body of a frame");

  a_idle_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && !is_byte && limit_i != 16'd0 && !timeout_hit)
      |=> (idle_q == $past(idle_q) + 16'd1))
    else $error("idle tick count did not advance by one");

endmodule

FILE: sv/crfr_obuf.sv
// Two-entry result buffer between the parser and the output stream.
module crfr_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  crfr_pkg::result_t push_data_i,
  output logic              ready_o,
  output logic              out_valid_o,
  output crfr_pkg::result_t out_data_o,
  input  logic              out_ready_i
);
  import crfr_pkg::*;

  result_t    ent0_q, ent0_d;
  result_t    ent1_q, ent1_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign ready_o     = count_q != 2'd2;
  assign out_valid_o = count_q != 2'd0;
  assign out_data_o  = ent0_q;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    ent0_d  = ent0_q;
    ent1_d  = ent1_q;
    count_d = count_q;
    if (pop && push_i) begin
      if (count_q == 2'd1) begin
        ent0_d = push_data_i;
      end else begin
        ent0_d = ent1_q;
        ent1_d = push_data_i;
      end
    end else if (pop) begin
      ent0_d  = ent1_q;
      count_d = count_q - 2'd1;
    end else if (push_i) begin
      if (count_q == 2'd0) ent0_d = push_data_i;
      else ent1_d = push_data_i;
      count_d = count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("result pushed into a full buffer");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  a_push_lands_at_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && count_q == 2'd0) |=> (out_valid_o && out_data_o == $past(push_data_i)))
    else $error("result pushed into an empty buffer is not at its head");

endmodule

FILE: sv/checksummed_frame_receiver_core.sv
// Top level of the checksummed frame receiver: input register, parser and result buffer.
//
//   Channel  | Direction | Beat contents
//   s_axis   | in        | tuser = action, tdata[7:0] = rx_byte
//   m_axis   | out       | tuser = kind, tdata = payload_byte, status, frame_length
//   cfg      | in        | cfg_wdata_i = timeout_limit, written when cfg_we_i is high
//
// One beat a cycle is taken and parsed while the result buffer has room; an accepted
// beat waits in the input register; any result is buffered and offered on m_axis.
// Reset (rst_ni low, asynchronous) empties both stages, returns the parser to
// hunting for a start byte and loads a timeout limit of 200 ticks.
// A stall on m_axis fills the two-entry result buffer; s_axis_tready then drops
// only once the input register also holds a beat that cannot move on.
module checksummed_frame_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic        s_axis_tuser,  // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] payload_byte, [9:8] status, [17:10] frame_length
  output logic        m_axis_tuser,  // [0] kind
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import crfr_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic        in_action_q;
  logic [7:0]  in_byte_q;
  logic [15:0] limit_q;

  logic        advance;
  logic        res_valid;
  result_t     res;
  logic        buf_ready;
  result_t     out_res;
  logic        s_accept;

  assign advance       = in_valid_q && buf_ready;
  assign s_axis_tready = !in_valid_q || buf_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_accept || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      limit_q    <= TIMEOUT_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_action_q <= s_axis_tuser;
      in_byte_q   <= s_axis_tdata;
    end
  end

  crfr_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (advance),
    .item_action_i (in_action_q),
    .item_byte_i   (in_byte_q),
    .limit_i       (limit_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  crfr_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {6'd0, out_res.frame_length, out_res.status, out_res.payload_byte};

endmodule
